// File: src/ppaq_pkg.sv
// ----------------------------------------------------------------------------
// ppaq_pkg: shared types and constants of the push-out admission queue
// Slot layout, status codes, register indexes and small helper functions.
// ----------------------------------------------------------------------------
package ppaq_pkg;

    localparam int QUEUE_DEPTH = 64;            // power of two: slot pointers wrap
    localparam int ADDR_W      = $clog2(QUEUE_DEPTH);
    localparam int CNT_W       = ADDR_W + 1;
    localparam int BATCH_ITEMS = 64;
    localparam int TAG_BITS    = 16;
    localparam int SIZE_BITS   = 20;
    localparam int BATCH_W     = 26;            // holds BATCH_ITEMS max-size entries
    localparam logic [19:0] NS_PER_MS = 20'd1000000;

    localparam logic [2:0] ST_ACCEPT  = 3'd0;
    localparam logic [2:0] ST_EVICTED = 3'd1;
    localparam logic [2:0] ST_FORCED  = 3'd2;
    localparam logic [2:0] ST_DROPPED = 3'd3;
    localparam logic [2:0] ST_DEQUEUE = 3'd4;
    localparam logic [2:0] ST_EMPTY   = 3'd5;

    localparam logic [1:0] REG_MAX_ITEMS   = 2'd0;
    localparam logic [1:0] REG_MAX_BYTES   = 2'd1;
    localparam logic [1:0] REG_SLOW_MS     = 2'd2;
    localparam logic [1:0] REG_BATCH_BYTES = 2'd3;

    localparam logic OP_ENQUEUE = 1'b0;
    localparam logic OP_DEQUEUE = 1'b1;

    typedef struct packed {
        logic [TAG_BITS-1:0]  tag;
        logic [SIZE_BITS-1:0] size;
        logic                 prio;
    } slot_t;

    function automatic logic [31:0] sat_inc(input logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    function automatic logic [31:0] sub_floor(input logic [31:0] sum,
                                              input logic [SIZE_BITS-1:0] size);
        logic [31:0] s;
        s = {{(32-SIZE_BITS){1'b0}}, size};
        return (s < sum) ? sum - s : 32'd0;
    endfunction

    function automatic logic is_full(input logic [CNT_W-1:0] occ,
                                     input logic [6:0] max_items,
                                     input logic [31:0] sum,
                                     input logic [SIZE_BITS-1:0] size,
                                     input logic [31:0] max_bytes);
        logic [32:0] total;
        total = {1'b0, sum} + {{(33-SIZE_BITS){1'b0}}, size};
        return ({{(7-CNT_W){1'b0}}, occ} >= max_items) ||
               (occ >= CNT_W'(QUEUE_DEPTH)) || (total > {1'b0, max_bytes});
    endfunction

endpackage

// File: src/ppaq_slot_ram.sv
// ----------------------------------------------------------------------------
// ppaq_slot_ram: slot storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module ppaq_slot_ram #(
    parameter int WIDTH = 37,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/priority_pushout_admission_queue_unit.sv
// ----------------------------------------------------------------------------
// priority_pushout_admission_queue_unit: bounded record queue with push-out
// Enqueue classifies a record and admits, evicts or drops it; dequeue pops
// a batch bounded by item count and byte budget.
// ----------------------------------------------------------------------------
// Usage:
//  Input channel (in_valid / in_stall) carries one word per operation:
//  opcode 0 enqueues the record fields, opcode 1 dequeues a batch.
//  in_stall is high whenever an operation is in progress; one word at a time.
//  Enqueue: the record is registered, classified and then admitted, forced
//  or dropped; when eviction is needed the sequencer first walks every
//  queued slot, reading it and then keeping or evicting it. Dequeue: each
//  entry is read from its slot; unless it ends the batch by occupancy or
//  item count, the next entry is read and its budget checked before the
//  entry appears. Empty: the result is valid right at the accepting edge.
//  Each result sits in the output register until out_stall is low; the
//  sequencer waits there, so a stalled receiver simply holds the block.
//  last marks the final result of an operation.
//  Reset empties the queue, clears counters and loads register defaults;
//  slot storage is not cleared and needs no sweep.
//  APB registers at 0x0,0x4,0x8,0xC: max_items, max_bytes,
//  slow_threshold_ms, batch_max_bytes. Write only while idle.
// ----------------------------------------------------------------------------
module priority_pushout_admission_queue_unit (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic        opcode,
    input  logic [15:0] record_tag,
    input  logic [19:0] record_size,
    input  logic        is_structural,
    input  logic        has_parent,
    input  logic        is_error,
    input  logic [62:0] start_ns,
    input  logic [62:0] end_ns,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  status,
    output logic [6:0]  evicted_count,
    output logic [15:0] out_tag,
    output logic [19:0] out_bytes,
    output logic        out_high_priority,
    output logic        last,
    output logic [6:0]  queued_items,
    output logic [31:0] queued_total_bytes,
    output logic [31:0] dropped_total,
    output logic [31:0] full_total
);

    import ppaq_pkg::*;

    localparam logic [3:0] S_IDLE    = 4'd0;
    localparam logic [3:0] S_CLS1    = 4'd1;
    localparam logic [3:0] S_CLS2    = 4'd2;
    localparam logic [3:0] S_DEC     = 4'd3;
    localparam logic [3:0] S_EV_RD   = 4'd4;
    localparam logic [3:0] S_EV_PROC = 4'd5;
    localparam logic [3:0] S_EV_END  = 4'd6;
    localparam logic [3:0] S_DQ_TAKE = 4'd7;
    localparam logic [3:0] S_DQ_CHK  = 4'd8;
    localparam logic [3:0] S_OUT     = 4'd9;

    // configuration
    logic [6:0]  max_items_reg;
    logic [31:0] max_bytes_reg, slow_ms_reg, batch_lim_reg;
    logic        cfg_wr;

    // control state
    logic [3:0]        state_reg, state_next;
    logic [ADDR_W-1:0] head_reg, head_next;
    logic [CNT_W-1:0]  occ_reg, occ_next;
    logic [31:0]       sum_reg, sum_next;
    logic [31:0]       drop_reg, drop_next;
    logic [31:0]       full_reg, full_next;
    logic [CNT_W-1:0]  scan_reg, scan_next;     // read position of eviction walk
    logic [CNT_W-1:0]  keep_reg, keep_next;     // write position of eviction walk
    logic [CNT_W-1:0]  orig_reg, orig_next;
    logic [6:0]        evict_reg, evict_next;
    logic [BATCH_W-1:0] batch_reg, batch_next;
    logic [6:0]        n_reg, n_next;
    logic              out_valid_reg, out_valid_next;

    // captured word and classification
    logic [TAG_BITS-1:0]  rec_tag_reg;
    logic [SIZE_BITS-1:0] rec_bytes_reg;
    logic                 rec_struct_reg, rec_root_reg, rec_err_reg;
    logic [62:0]          rec_start_reg, rec_end_reg;
    logic [62:0]          diff_reg;
    logic                 gt_reg;
    logic [51:0]          prod_reg;
    logic                 high_reg, high_next;

    // output payload
    logic [2:0]  out_status_reg, out_status_next;
    logic [6:0]  out_evict_reg, out_evict_next;
    logic [15:0] out_tag_reg, out_tag_next;
    logic [19:0] out_bytes_reg, out_bytes_next;
    logic        out_prio_reg, out_prio_next;
    logic        out_last_reg, out_last_next;

    // slot memory port
    logic              mem_we, mem_re;
    logic [ADDR_W-1:0] mem_waddr, mem_raddr;
    slot_t             mem_wdata, mem_rdata;

    logic in_acc, out_acc, full_now;
    logic [32:0] batch_try;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite;

    always_comb
    begin
        unique case (paddr[3:2])
            REG_MAX_ITEMS:   prdata = {25'd0, max_items_reg};
            REG_MAX_BYTES:   prdata = max_bytes_reg;
            REG_SLOW_MS:     prdata = slow_ms_reg;
            REG_BATCH_BYTES: prdata = batch_lim_reg;
            default:         prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            max_items_reg   <= 7'd64;
            max_bytes_reg   <= 32'd4194304;
            slow_ms_reg     <= 32'd0;
            batch_lim_reg   <= 32'd524288;
        end
        else if (cfg_wr)
        begin
            unique case (paddr[3:2])
                REG_MAX_ITEMS:   max_items_reg   <= pwdata[6:0];
                REG_MAX_BYTES:   max_bytes_reg   <= pwdata;
                REG_SLOW_MS:     slow_ms_reg     <= pwdata;
                REG_BATCH_BYTES: batch_lim_reg   <= pwdata;
                default:         ;
            endcase
        end
    end

    ppaq_slot_ram #(
        .WIDTH ($bits(slot_t)),
        .DEPTH (QUEUE_DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign in_stall = (state_reg != S_IDLE);
    assign in_acc   = in_valid & ~in_stall;
    assign out_acc  = out_valid_reg & ~out_stall;
    assign full_now = is_full(occ_reg, max_items_reg, sum_reg, rec_bytes_reg, max_bytes_reg);
    assign batch_try = {{(33-BATCH_W){1'b0}}, batch_reg}
                     + {{(33-SIZE_BITS){1'b0}}, mem_rdata.size};

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        occ_next        = occ_reg;
        sum_next        = sum_reg;
        drop_next       = drop_reg;
        full_next       = full_reg;
        scan_next       = scan_reg;
        keep_next       = keep_reg;
        orig_next       = orig_reg;
        evict_next      = evict_reg;
        batch_next      = batch_reg;
        n_next          = n_reg;
        high_next       = high_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_evict_next  = out_evict_reg;
        out_tag_next    = out_tag_reg;
        out_bytes_next  = out_bytes_reg;
        out_prio_next   = out_prio_reg;
        out_last_next   = out_last_reg;
        mem_we          = 1'b0;
        mem_waddr       = head_reg + occ_reg[ADDR_W-1:0];
        mem_wdata       = '{tag: rec_tag_reg, size: rec_bytes_reg, prio: 1'b1};
        mem_re          = 1'b0;
        mem_raddr       = head_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_acc)
                begin
                    out_tag_next   = '0;
                    out_bytes_next = '0;
                    out_prio_next  = 1'b0;
                    out_evict_next = '0;
                    out_last_next  = 1'b1;
                    if (opcode == OP_ENQUEUE)
                    begin
                        state_next = S_CLS1;
                    end
                    else if (occ_reg == '0)
                    begin
                        out_status_next = ST_EMPTY;
                        out_valid_next  = 1'b1;
                        state_next      = S_OUT;
                    end
                    else
                    begin
                        mem_re     = 1'b1;
                        n_next     = '0;
                        batch_next = '0;
                        state_next = S_DQ_TAKE;
                    end
                end
            end
            S_CLS1:
            begin
                state_next = S_CLS2;
            end
            S_CLS2:
            begin
                high_next = rec_struct_reg | rec_root_reg | rec_err_reg |
                            ((slow_ms_reg != 32'd0) && gt_reg &&
                             (diff_reg >= {11'd0, prod_reg}));
                state_next = S_DEC;
            end
            S_DEC:
            begin
                if (!full_now)
                begin
                    mem_we          = 1'b1;
                    mem_wdata.prio  = high_reg;
                    occ_next        = occ_reg + 1'b1;
                    sum_next        = sum_reg + {12'd0, rec_bytes_reg};
                    out_status_next = ST_ACCEPT;
                    out_valid_next  = 1'b1;
                    state_next      = S_OUT;
                end
                else
                begin
                    full_next = sat_inc(full_reg);
                    if (rec_struct_reg)
                    begin
                        if (occ_reg < CNT_W'(QUEUE_DEPTH))
                        begin
                            mem_we          = 1'b1;
                            occ_next        = occ_reg + 1'b1;
                            sum_next        = sum_reg + {12'd0, rec_bytes_reg};
                            out_status_next = ST_FORCED;
                        end
                        else
                        begin
                            drop_next       = sat_inc(drop_reg);
                            out_status_next = ST_DROPPED;
                        end
                        out_valid_next = 1'b1;
                        state_next     = S_OUT;
                    end
                    else if (high_reg)
                    begin
                        scan_next  = '0;
                        keep_next  = '0;
                        orig_next  = occ_reg;
                        evict_next = '0;
                        state_next = S_EV_RD;
                    end
                    else
                    begin
                        drop_next       = sat_inc(drop_reg);
                        out_status_next = ST_DROPPED;
                        out_valid_next  = 1'b1;
                        state_next      = S_OUT;
                    end
                end
            end
            S_EV_RD:
            begin
                if (scan_reg == orig_reg)
                begin
                    state_next = S_EV_END;
                end
                else
                begin
                    mem_re     = 1'b1;
                    mem_raddr  = head_reg + scan_reg[ADDR_W-1:0];
                    state_next = S_EV_PROC;
                end
            end
            S_EV_PROC:
            begin
                // oldest low-priority entries go while the record still does not fit
                if (!mem_rdata.prio && full_now)
                begin
                    occ_next   = occ_reg - 1'b1;
                    sum_next   = sub_floor(sum_reg, mem_rdata.size);
                    drop_next  = sat_inc(drop_reg);
                    evict_next = evict_reg + 7'd1;
                end
                else
                begin
                    mem_we    = 1'b1;
                    mem_waddr = head_reg + keep_reg[ADDR_W-1:0];
                    mem_wdata = mem_rdata;
                    keep_next = keep_reg + 1'b1;
                end
                scan_next  = scan_reg + 1'b1;
                state_next = S_EV_RD;
            end
            S_EV_END:
            begin
                out_evict_next = evict_reg;
                if ((evict_reg != 7'd0) && !full_now)
                begin
                    mem_we          = 1'b1;
                    occ_next        = occ_reg + 1'b1;
                    sum_next        = sum_reg + {12'd0, rec_bytes_reg};
                    out_status_next = ST_EVICTED;
                end
                else
                begin
                    drop_next       = sat_inc(drop_reg);
                    out_status_next = ST_DROPPED;
                end
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
            S_DQ_TAKE:
            begin
                out_status_next = ST_DEQUEUE;
                out_evict_next  = '0;
                out_tag_next    = mem_rdata.tag;
                out_bytes_next  = mem_rdata.size;
                out_prio_next   = mem_rdata.prio;
                batch_next      = batch_try[BATCH_W-1:0];
                head_next       = head_reg + 1'b1;
                occ_next        = occ_reg - 1'b1;
                sum_next        = sub_floor(sum_reg, mem_rdata.size);
                n_next          = n_reg + 7'd1;
                if ((occ_reg == CNT_W'(1)) || (n_reg == 7'(BATCH_ITEMS - 1)))
                begin
                    out_last_next  = 1'b1;
                    out_valid_next = 1'b1;
                    state_next     = S_OUT;
                end
                else
                begin
                    // fetch the next head to decide whether this word is last
                    mem_re     = 1'b1;
                    mem_raddr  = head_reg + 1'b1;
                    state_next = S_DQ_CHK;
                end
            end
            S_DQ_CHK:
            begin
                out_last_next  = (batch_try > {1'b0, batch_lim_reg});
                out_valid_next = 1'b1;
                state_next     = S_OUT;
            end
            S_OUT:
            begin
                if (out_acc)
                begin
                    out_valid_next = 1'b0;
                    state_next     = out_last_reg ? S_IDLE : S_DQ_TAKE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            occ_reg       <= '0;
            sum_reg       <= '0;
            drop_reg      <= '0;
            full_reg      <= '0;
            scan_reg      <= '0;
            keep_reg      <= '0;
            orig_reg      <= '0;
            evict_reg     <= '0;
            batch_reg     <= '0;
            n_reg         <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            occ_reg       <= occ_next;
            sum_reg       <= sum_next;
            drop_reg      <= drop_next;
            full_reg      <= full_next;
            scan_reg      <= scan_next;
            keep_reg      <= keep_next;
            orig_reg      <= orig_next;
            evict_reg     <= evict_next;
            batch_reg     <= batch_next;
            n_reg         <= n_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            rec_tag_reg    <= record_tag;
            rec_bytes_reg  <= record_size;
            rec_struct_reg <= is_structural;
            rec_root_reg   <= ~has_parent;
            rec_err_reg    <= is_error;
            rec_start_reg  <= start_ns;
            rec_end_reg    <= end_ns;
        end
        if (state_reg == S_CLS1)
        begin
            // floor(d / 1e6) >= t  <=>  d >= t * 1e6
            diff_reg <= rec_end_reg - rec_start_reg;
            gt_reg   <= (rec_end_reg > rec_start_reg);
            prod_reg <= slow_ms_reg * NS_PER_MS;
        end
        high_reg       <= high_next;
        out_status_reg <= out_status_next;
        out_evict_reg  <= out_evict_next;
        out_tag_reg    <= out_tag_next;
        out_bytes_reg  <= out_bytes_next;
        out_prio_reg   <= out_prio_next;
        out_last_reg   <= out_last_next;
    end

    assign out_valid          = out_valid_reg;
    assign status             = out_status_reg;
    assign evicted_count      = out_evict_reg;
    assign out_tag            = out_tag_reg;
    assign out_bytes          = out_bytes_reg;
    assign out_high_priority  = out_prio_reg;
    assign last               = out_last_reg;
    assign queued_items       = {{(7-CNT_W){1'b0}}, occ_reg};
    assign queued_total_bytes = sum_reg;
    assign dropped_total      = drop_reg;
    assign full_total         = full_reg;

    a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
        occ_reg <= CNT_W'(QUEUE_DEPTH))
        else $error("occupancy beyond depth");

    a_out_in_state: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> (state_reg == S_OUT))
        else $error("result shown outside output state");

    a_idle_no_word: assert property (@(posedge clk) disable iff (!rst_n)
        !in_stall |-> !out_valid_reg)
        else $error("ready while a result waits");

    a_evict_status: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_evict_reg != 7'd0)) |->
        ((out_status_reg == ST_EVICTED) || (out_status_reg == ST_DROPPED)))
        else $error("eviction count on wrong status");

    a_walk_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EV_PROC) |-> (keep_reg <= scan_reg))
        else $error("compaction write passed read");

endmodule

// File: tb/ppaq_checker.sv
// ----------------------------------------------------------------------------
// ppaq_checker: result predictor and comparator for the admission queue
// Watches the APB port and both word channels. It keeps its own copy of the
// queue and the registers, predicts the results of every accepted word and
// compares each accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module ppaq_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    input  logic        in_valid,
    input  logic        in_stall,
    input  logic        opcode,
    input  logic [15:0] record_tag,
    input  logic [19:0] record_size,
    input  logic        is_structural,
    input  logic        has_parent,
    input  logic        is_error,
    input  logic [62:0] start_ns,
    input  logic [62:0] end_ns,
    input  logic        out_valid,
    input  logic        out_stall,
    input  logic [2:0]  status,
    input  logic [6:0]  evicted_count,
    input  logic [15:0] out_tag,
    input  logic [19:0] out_bytes,
    input  logic        out_high_priority,
    input  logic        last,
    input  logic [6:0]  queued_items,
    input  logic [31:0] queued_total_bytes,
    input  logic [31:0] dropped_total,
    input  logic [31:0] full_total,
    output int          fail_count,
    output int          pending_count
);

    import ppaq_pkg::*;

    typedef struct packed {
        logic [2:0]  status;
        logic [6:0]  evicted;
        logic [15:0] tag;
        logic [19:0] bytes;
        logic        prio;
        logic        last;
        logic [6:0]  items;
        logic [31:0] total;
        logic [31:0] dropped;
        logic [31:0] full;
    } outcome_t;

    outcome_t    expected_q[$];
    logic [6:0]  lim_items;
    logic [31:0] lim_bytes, slow_ms, batch_lim;
    logic [15:0] q_tag[$];
    logic [19:0] q_size[$];
    logic        q_prio[$];
    logic [31:0] q_sum, drops, fulls;

    assign pending_count = expected_q.size();

    function automatic logic no_room_for(logic [19:0] b);
        return q_tag.size() >= lim_items || q_tag.size() >= QUEUE_DEPTH ||
               {32'd0, q_sum} + b > {32'd0, lim_bytes};
    endfunction

    function automatic logic [31:0] bump(logic [31:0] c);
        return (c == 32'hFFFF_FFFF) ? c : c + 32'd1;
    endfunction

    task automatic drop_slot(int i);
        q_sum = (q_size[i] < q_sum) ? q_sum - q_size[i] : 32'd0;
        q_tag.delete(i);
        q_size.delete(i);
        q_prio.delete(i);
    endtask

    task automatic add_slot(logic [15:0] t, logic [19:0] b, logic p);
        q_tag.insert(q_tag.size(), t);
        q_size.insert(q_size.size(), b);
        q_prio.insert(q_prio.size(), p);
        q_sum = q_sum + b;
    endtask

    task automatic post(logic [2:0] st, logic [6:0] ev, logic [15:0] t, logic [19:0] b,
                        logic p, logic l);
        outcome_t o;
        o = '{st, ev, t, b, p, l, 7'(q_tag.size()), q_sum, drops, fulls};
        expected_q.insert(expected_q.size(), o);
    endtask

    task automatic predict_word();
        logic        slow, high;
        logic [62:0] dur;
        int          ev, i, n;
        logic [63:0] batch;
        logic [15:0] t;
        logic [19:0] s;
        logic        p;
        ev = 0;
        if (opcode == OP_ENQUEUE) begin
            dur = end_ns - start_ns;
            slow = slow_ms != 0 && end_ns > start_ns && (dur / 63'd1000000) >= slow_ms;
            high = is_structural || !has_parent || is_error || slow;
            if (!no_room_for(record_size)) begin
                add_slot(record_tag, record_size, high);
                post(ST_ACCEPT, 0, 0, 0, 0, 1);
                return;
            end
            fulls = bump(fulls);
            if (is_structural) begin
                if (q_tag.size() < QUEUE_DEPTH) begin
                    add_slot(record_tag, record_size, 1'b1);
                    post(ST_FORCED, 0, 0, 0, 0, 1);
                end else begin
                    drops = bump(drops);
                    post(ST_DROPPED, 0, 0, 0, 0, 1);
                end
                return;
            end
            if (high) begin
                while (no_room_for(record_size) && q_tag.size() > 0) begin
                    i = 0;
                    while (i < q_tag.size() && q_prio[i])
                        i++;
                    if (i >= q_tag.size())
                        break;
                    drop_slot(i);
                    drops = bump(drops);
                    ev++;
                end
                if (ev > 0 && !no_room_for(record_size)) begin
                    add_slot(record_tag, record_size, 1'b1);
                    post(ST_EVICTED, 7'(ev), 0, 0, 0, 1);
                    return;
                end
            end
            drops = bump(drops);
            post(ST_DROPPED, 7'(ev), 0, 0, 0, 1);
        end else begin
            if (q_tag.size() == 0) begin
                post(ST_EMPTY, 0, 0, 0, 0, 1);
                return;
            end
            n = 0;
            batch = 0;
            while (q_tag.size() > 0 && n < BATCH_ITEMS) begin
                t = q_tag[0];
                s = q_size[0];
                p = q_prio[0];
                if (n > 0 && batch + s > {32'd0, batch_lim})
                    break;
                batch = batch + s;
                drop_slot(0);
                post(ST_DEQUEUE, 0, t, s, p, 0);
                n++;
            end
            expected_q[$].last = 1'b1;
        end
    endtask

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v) begin
            $error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        outcome_t e;
        if (!rst_n) begin
            lim_items   <= 7'd64;
            lim_bytes   <= 32'd4194304;
            slow_ms     <= 32'd0;
            batch_lim   <= 32'd524288;
            q_tag.delete();
            q_size.delete();
            q_prio.delete();
            q_sum = 0;
            drops = 0;
            fulls = 0;
            fail_count = 0;
            expected_q.delete();
        end else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[3:2])
                    REG_MAX_ITEMS:   lim_items   <= pwdata[6:0];
                    REG_MAX_BYTES:   lim_bytes   <= pwdata;
                    REG_SLOW_MS:     slow_ms     <= pwdata;
                    REG_BATCH_BYTES: batch_lim   <= pwdata;
                    default: ;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (expected_q.size() == 0) begin
                    $error("result word with no prediction waiting");
                    fail_count++;
                end else begin
                    e = expected_q[0];
                    expected_q.delete(0);
                    check_field("status", e.status, status);
                    check_field("evicted_count", e.evicted, evicted_count);
                    check_field("out_tag", e.tag, out_tag);
                    check_field("out_bytes", e.bytes, out_bytes);
                    check_field("out_high_priority", e.prio, out_high_priority);
                    check_field("last", e.last, last);
                    check_field("queued_items", e.items, queued_items);
                    check_field("queued_total_bytes", e.total, queued_total_bytes);
                    check_field("dropped_total", e.dropped, dropped_total);
                    check_field("full_total", e.full, full_total);
                end
            end
            if (in_valid && !in_stall)
                predict_word();
        end
    end

endmodule

// File: tb/tb.sv
// ----------------------------------------------------------------------------
// tb: stimulus and verdict for the priority push-out admission queue
// Programs register settings over APB, sends directed then random enqueue and
// dequeue words under several idle and stall mixes; the checker compares.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb;
    import ppaq_pkg::*;

    logic        clk, rst_n;
    logic        psel, penable, pwrite;
    logic [3:0]  paddr;
    logic [31:0] pwdata, prdata;
    logic        pready;
    logic        in_valid, in_stall, opcode;
    logic [15:0] record_tag;
    logic [19:0] record_size;
    logic        is_structural, has_parent, is_error;
    logic [62:0] start_ns, end_ns;
    logic        out_valid, out_stall;
    logic [2:0]  status;
    logic [6:0]  evicted_count, queued_items;
    logic [15:0] out_tag;
    logic [19:0] out_bytes;
    logic        out_high_priority, last;
    logic [31:0] queued_total_bytes, dropped_total, full_total;
    int          fail_count, pending_count;
    int          send_idle_pct, stall_pct;
    int          cycles;

    priority_pushout_admission_queue_unit u_top (.*);

    ppaq_checker u_chk (.*);

    initial begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    // cycle limit: worst case ~64 results per word, each stalled long
    initial begin
        cycles = 0;
        forever begin
            @(posedge clk);
            cycles++;
            if (cycles > 1500000) begin
                $display("== FAIL ==");
                $finish;
            end
        end
    end

    always @(negedge clk)
        out_stall <= ($urandom_range(99) < stall_pct);

    task automatic apb_write(logic [1:0] idx, logic [31:0] v);
        @(negedge clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= v;
        @(negedge clk);
        penable <= 1;
        @(negedge clk);
        psel <= 0; penable <= 0; pwrite <= 0;
    endtask

    task automatic drain();
        while (pending_count != 0)
            @(negedge clk);
        repeat (2 * QUEUE_DEPTH * 3 + 20) @(negedge clk);
    endtask

    task automatic setup_regs(logic [6:0] mi, logic [31:0] mb, logic [31:0] sm,
                              logic [31:0] bb);
        drain();
        apb_write(REG_MAX_ITEMS, {25'd0, mi});
        apb_write(REG_MAX_BYTES, mb);
        apb_write(REG_SLOW_MS, sm);
        apb_write(REG_BATCH_BYTES, bb);
    endtask

    // one word, held until accepted
    task automatic send_word(logic op, logic [15:0] t, logic [19:0] b, logic st,
                             logic par, logic er, logic [62:0] s0, logic [62:0] s1);
        @(negedge clk);
        while ($urandom_range(99) < send_idle_pct)
            @(negedge clk);
        in_valid <= 1; opcode <= op; record_tag <= t; record_size <= b;
        is_structural <= st; has_parent <= par; is_error <= er;
        start_ns <= s0; end_ns <= s1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        @(negedge clk);
        in_valid <= 0;
    endtask

    task automatic rand_word(int deq_pct, int big_pct);
        logic [62:0] s0;
        logic [19:0] b;
        s0 = 63'({$urandom, $urandom});
        if ($urandom_range(3) == 0)
            s0 = 63'($urandom_range(1000));
        b = ($urandom_range(99) < big_pct) ? 20'($urandom) : 20'($urandom_range(4000));
        send_word($urandom_range(99) < deq_pct, 16'($urandom), b,
                  $urandom_range(9) == 0, $urandom_range(9) != 0, $urandom_range(9) == 0,
                  s0, s0 + ($urandom_range(1) ? 63'($urandom_range(50)) * 63'd1000000
                                              : 63'({$urandom, $urandom})));
    endtask

    initial begin
        rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        in_valid = 0; opcode = 0; record_tag = 0; record_size = 0;
        is_structural = 0; has_parent = 0; is_error = 0; start_ns = 0; end_ns = 0;
        out_stall = 0; send_idle_pct = 0; stall_pct = 0;
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n = 1;

        // directed: empty dequeue, extremes, each class, forced and eviction
        send_word(OP_DEQUEUE, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_ENQUEUE, 16'hFFFF, 20'hFFFFF, 0, 1, 0, 63'h7FFF_FFFF_FFFF_FFFF, 0);
        send_word(OP_ENQUEUE, 16'h0000, 20'h0, 1, 1, 1, 0, 63'h7FFF_FFFF_FFFF_FFFF);
        send_word(OP_ENQUEUE, 16'h1234, 20'h100, 0, 0, 0, 5, 5);
        send_word(OP_DEQUEUE, 0, 0, 0, 0, 0, 0, 0);
        setup_regs(7'd3, 32'd1000, 32'd2, 32'd0);
        send_word(OP_ENQUEUE, 1, 300, 0, 1, 0, 0, 63'd1000);
        send_word(OP_ENQUEUE, 2, 300, 0, 1, 0, 0, 63'd1000);
        send_word(OP_ENQUEUE, 3, 300, 0, 1, 0, 0, 63'd1000);
        send_word(OP_ENQUEUE, 4, 300, 0, 1, 0, 0, 63'd1000);    // low, full: drop
        send_word(OP_ENQUEUE, 5, 300, 0, 1, 0, 0, 63'd2000000); // slow: evict
        send_word(OP_ENQUEUE, 6, 900, 0, 1, 1, 0, 0);           // error: evicts all low, still no fit: drop
        send_word(OP_ENQUEUE, 7, 900, 0, 1, 1, 0, 0);           // no low left: drop
        send_word(OP_ENQUEUE, 8, 50, 1, 1, 0, 0, 0);            // structural, room left: accept
        send_word(OP_DEQUEUE, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_DEQUEUE, 0, 0, 0, 0, 0, 0, 0);
        setup_regs(7'd0, 32'd0, 32'hFFFF_FFFF, 32'd1);
        for (int i = 0; i < 66; i++)
            send_word(OP_ENQUEUE, 16'(i), 0, 1, 1, 0, 0, 0);    // past physical depth
        send_word(OP_DEQUEUE, 0, 0, 0, 0, 0, 0, 0);
        send_word(OP_DEQUEUE, 0, 0, 0, 0, 0, 0, 0);

        for (int ph = 0; ph < 4; ph++) begin
            case (ph)
                0: setup_regs(7'd64, 32'hFFFF_FFFF, 32'd0, 32'hFFFF_FFFF);
                1: setup_regs(7'd8, 32'd6000, 32'd20, 32'd3000);
                2: setup_regs(7'd127, 32'd4194304, 32'd1, 32'd1);
                default: setup_regs(7'd20, 32'd20000, 32'hFFFF_FFFF, 32'd524288);
            endcase
            send_idle_pct = (ph == 1 || ph == 3) ? ((ph == 3) ? 24 : 82) : 0;
            stall_pct = (ph == 2) ? 82 : (ph == 3) ? 24 : 0;
            for (int k = 0; k < 87; k++) begin
                if (k == 40)
                    while (pending_count != 0)
                        @(negedge clk);
                rand_word((ph == 2) ? 15 : 30, (ph == 0) ? 30 : 3);
            end
        end

        stall_pct = 0;
        while (pending_count != 0)
            @(negedge clk);
        repeat (2 * QUEUE_DEPTH * 3 + 20) @(negedge clk);
        if (fail_count == 0 && pending_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// File: files.f
src/ppaq_pkg.sv
src/ppaq_slot_ram.sv
src/priority_pushout_admission_queue_unit.sv
tb/ppaq_checker.sv
tb/tb.sv
